### src/arq_pkg.sv
// ----------------------------------------------------------------------------
// arq_pkg
// Types and constants shared by the announce receive qualifier files.
// ----------------------------------------------------------------------------
`default_nettype none

package arq_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_PATH   = 2'd1,
        OP_READ   = 2'd2,
        OP_BEGIN  = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DISCARDED = 3'd0,
        ST_QUALIFIED = 3'd1,
        ST_SELF      = 3'd2,
        ST_STEPS     = 3'd3,
        ST_TRAVERSED = 3'd4,
        ST_READ      = 3'd5,
        ST_BEGIN     = 3'd6
    } t_status;

    // Receive machine states, one-hot
    typedef enum logic [1:0] {
        RX_DISCARD = 2'b01,
        RX_RECEIVE = 2'b10
    } t_rx_state;

    // Source of the trace entry shown with a result
    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_MEM  = 2'd1,
        SEL_TAIL = 2'd2
    } t_entry_sel;

    // Register indexes (byte address / 8)
    typedef enum logic [1:0] {
        REG_CLOCK_ID    = 2'd0,
        REG_EXT_CONFIG  = 2'd1,
        REG_INST_ENABLE = 2'd2
    } t_reg_idx;

    localparam logic [15:0] STEPS_LIMIT    = 16'd255;
    localparam logic [15:0] TLV_PATH_TRACE = 16'h0008;
    localparam int          PADDR_W        = 5;

    typedef struct packed {
        t_op         operation;
        logic [63:0] source_clock_id;
        logic [15:0] steps_removed;
        logic [15:0] tlv_type;
        logic [15:0] tlv_length;
        logic [63:0] path_clock_id;
        logic        port_active;
        logic        port_enabled;
        logic        link_capable;
        logic        is_slave_port;
        logic [3:0]  read_index;
    } t_item;

    typedef struct packed {
        logic        qualified;
        t_status     status;
        logic [4:0]  path_trace_count;
        logic [63:0] trace_entry;
        logic        in_receive;
    } t_result;

endpackage

`default_nettype wire

### src/arq_ifs.sv
// ----------------------------------------------------------------------------
// arq item and result channels
// Valid/ready channels carrying one input item or one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface arq_item_if;
    logic           valid;
    logic           ready;
    arq_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arq_result_if;
    logic             valid;
    logic             ready;
    arq_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/arq_trace_ram.sv
// ----------------------------------------------------------------------------
// arq_trace_ram
// Two-bank path trace store: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arq_trace_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [63:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output      logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/announce_receive_qualifier.sv
// ----------------------------------------------------------------------------
// announce_receive_qualifier
// Announce receive machine (discard/receive) with announce qualification
// and a double-banked path trace fed one identity per path entry item.
// ----------------------------------------------------------------------------
// An accepted item sits in the input register; its result loads into the
//   result register when the item advances out of the input register.
// Throughput: one item per cycle; ready drops only while the result
//   register holds an untaken result.
// Reset (synchronous, i_rst_n low): discard state, trace cleared, count 0,
//   no scan pending. Trace store contents are not cleared; no sweep.
`default_nettype none

module announce_receive_qualifier #(
    parameter int MAX_TRACE = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    arq_item_if.sink                          i_item,
    arq_result_if.source                      o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [arq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [63:0]                  pwdata,
    output      logic [63:0]                  prdata,
    output      logic                         pready
);

    localparam int DEPTH = 2 * MAX_TRACE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_TRACE);       // committed count < MAX_TRACE
    localparam int TW    = $clog2(MAX_TRACE + 1);   // scan total/index up to MAX_TRACE
    localparam int CMPW  = (CW > 4) ? CW : 4;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [63:0] r_this_id;
    logic        r_ext_cfg;
    logic        r_inst_en;
    logic        cfg_we;

    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_this_id <= '0;
            r_ext_cfg <= 1'b0;
            r_inst_en <= 1'b1;
        end else if (cfg_we) begin
            case (arq_pkg::t_reg_idx'(paddr[4:3]))
                arq_pkg::REG_CLOCK_ID:    r_this_id <= pwdata;
                arq_pkg::REG_EXT_CONFIG:  r_ext_cfg <= pwdata[0];
                arq_pkg::REG_INST_ENABLE: r_inst_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (arq_pkg::t_reg_idx'(paddr[4:3]))
            arq_pkg::REG_CLOCK_ID:    prdata = r_this_id;
            arq_pkg::REG_EXT_CONFIG:  prdata = {63'd0, r_ext_cfg};
            arq_pkg::REG_INST_ENABLE: prdata = {63'd0, r_inst_en};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline handshake
    // ------------------------------------------------------------------
    logic                 r_in_valid;
    arq_pkg::t_item       r_in;
    logic                 r_out_valid;
    logic                 advance;

    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
    end

    // ------------------------------------------------------------------
    // machine state
    // ------------------------------------------------------------------
    arq_pkg::t_rx_state r_rx,      n_rx;
    logic               r_bank,    n_bank;
    logic               r_cleared, n_cleared;
    logic [CW-1:0]      r_count,   n_count;
    logic [TW-1:0]      r_total,   n_total;
    logic [TW-1:0]      r_index,   n_index;
    logic               r_rej,     n_rej;
    logic               r_slave,   n_slave;
    logic [63:0]        r_tail,    n_tail;

    // result of the item in the input register
    logic                 emit;
    arq_pkg::t_status     res_status;
    arq_pkg::t_entry_sel  res_sel;

    // store ports
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [63:0]          mem_rdata;

    // scan finish request
    logic                 fin_req;
    logic [TW-1:0]        fin_total;
    logic                 fin_rej;
    logic                 fin_slave;

    // header decode helpers
    logic                 usable;
    logic                 forced;
    logic [12:0]          tlv_ids;
    logic [TW-1:0]        hdr_n;
    logic [AW-1:0]        staging_base;
    logic [AW-1:0]        active_base;
    logic [CMPW-1:0]      rd_idx;
    logic                 rd_hit;
    logic                 rd_tail;
    logic                 path_rej;

    assign usable       = r_in.port_active && r_in.port_enabled && r_in.link_capable;
    assign forced       = (!r_inst_en || !usable) && !r_ext_cfg;
    assign tlv_ids      = r_in.tlv_length[15:3];
    assign hdr_n        = (tlv_ids > 13'(MAX_TRACE)) ? TW'(MAX_TRACE) : TW'(tlv_ids);
    assign staging_base = r_bank ? '0 : AW'(MAX_TRACE);
    assign active_base  = r_bank ? AW'(MAX_TRACE) : '0;
    assign rd_idx       = CMPW'(r_in.read_index);
    assign rd_hit       = !r_cleared && (rd_idx < CMPW'(r_count));
    assign rd_tail      = rd_hit && (rd_idx == (CMPW'(r_count) - CMPW'(1)));
    assign path_rej     = r_rej || (r_in.path_clock_id == r_this_id);

    assign mem_waddr    = staging_base + AW'(r_index);
    assign mem_raddr    = active_base + AW'(r_in.read_index);

    // per-item processing
    always_comb begin
        n_rx       = r_rx;
        n_bank     = r_bank;
        n_cleared  = r_cleared;
        n_count    = r_count;
        n_total    = r_total;
        n_index    = r_index;
        n_rej      = r_rej;
        n_slave    = r_slave;
        n_tail     = r_tail;
        emit       = 1'b0;
        res_status = arq_pkg::ST_DISCARDED;
        res_sel    = arq_pkg::SEL_ZERO;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        fin_req    = 1'b0;
        fin_total  = r_total;
        fin_rej    = r_rej;
        fin_slave  = r_slave;

        case (r_in.operation)
            arq_pkg::OP_BEGIN: begin
                n_rx       = arq_pkg::RX_DISCARD;
                n_total    = '0;
                n_index    = '0;
                emit       = 1'b1;
                res_status = arq_pkg::ST_BEGIN;
            end
            arq_pkg::OP_READ: begin
                emit       = 1'b1;
                res_status = arq_pkg::ST_READ;
                if (rd_tail) begin
                    res_sel = arq_pkg::SEL_TAIL;
                end else if (rd_hit) begin
                    res_sel = arq_pkg::SEL_MEM;
                    mem_re  = advance;
                end
            end
            arq_pkg::OP_PATH: begin
                // stray entries with no scan pending are dropped
                if (r_index < r_total) begin
                    mem_we  = advance;
                    n_rej   = path_rej;
                    n_index = r_index + TW'(1);
                    if (r_index + TW'(1) == r_total) begin
                        fin_req = 1'b1;
                        fin_rej = path_rej;
                    end
                end
            end
            default: begin
                // announce header
                n_total = '0;
                n_index = '0;
                if (forced) begin
                    n_rx       = arq_pkg::RX_DISCARD;
                    emit       = 1'b1;
                    res_status = arq_pkg::ST_DISCARDED;
                end else if ((r_rx == arq_pkg::RX_DISCARD) && !usable) begin
                    emit       = 1'b1;
                    res_status = arq_pkg::ST_DISCARDED;
                end else begin
                    n_rx = arq_pkg::RX_RECEIVE;
                    if (r_in.source_clock_id == r_this_id) begin
                        emit       = 1'b1;
                        res_status = arq_pkg::ST_SELF;
                    end else if (r_in.steps_removed >= arq_pkg::STEPS_LIMIT) begin
                        emit       = 1'b1;
                        res_status = arq_pkg::ST_STEPS;
                    end else if (r_in.tlv_type == arq_pkg::TLV_PATH_TRACE) begin
                        n_total = hdr_n;
                        n_rej   = 1'b0;
                        n_slave = r_in.is_slave_port;
                        if (hdr_n == '0) begin
                            fin_req   = 1'b1;
                            fin_total = '0;
                            fin_rej   = 1'b0;
                            fin_slave = r_in.is_slave_port;
                        end
                    end else begin
                        n_cleared  = 1'b1;
                        emit       = 1'b1;
                        res_status = arq_pkg::ST_QUALIFIED;
                    end
                end
            end
        endcase

        // verdict at the end of a scan; on a commit, own identity kept as the tail entry
        if (fin_req) begin
            n_total = '0;
            n_index = '0;
            emit    = 1'b1;
            if (fin_rej) begin
                res_status = arq_pkg::ST_TRAVERSED;
            end else begin
                res_status = arq_pkg::ST_QUALIFIED;
                if (fin_slave) begin
                    if (({1'b0, fin_total} + (TW+1)'(1)) < (TW+1)'(MAX_TRACE)) begin
                        n_bank    = !r_bank;
                        n_count   = CW'({1'b0, fin_total} + (TW+1)'(1));
                        n_cleared = 1'b0;
                        n_tail    = r_this_id;
                    end else begin
                        n_count = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx      <= arq_pkg::RX_DISCARD;
            r_bank    <= 1'b0;
            r_cleared <= 1'b1;
            r_count   <= '0;
            r_total   <= '0;
            r_index   <= '0;
            r_rej     <= 1'b0;
            r_slave   <= 1'b0;
        end else if (advance) begin
            r_rx      <= n_rx;
            r_bank    <= n_bank;
            r_cleared <= n_cleared;
            r_count   <= n_count;
            r_total   <= n_total;
            r_index   <= n_index;
            r_rej     <= n_rej;
            r_slave   <= n_slave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_tail <= n_tail;
        end
    end

    // ------------------------------------------------------------------
    // path trace store
    // ------------------------------------------------------------------
    arq_trace_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_trace_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_in.path_clock_id),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    arq_pkg::t_status     r_out_status;
    logic [4:0]           r_out_count;
    logic                 r_out_rx;
    arq_pkg::t_entry_sel  r_out_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_status <= res_status;
            r_out_count  <= 5'(n_count);
            r_out_rx     <= (n_rx == arq_pkg::RX_RECEIVE);
            r_out_sel    <= res_sel;
        end
    end

    // entry mux after the register; store data arrives with the result
    always_comb begin
        o_res.data.qualified        = (r_out_status == arq_pkg::ST_QUALIFIED);
        o_res.data.status           = r_out_status;
        o_res.data.path_trace_count = r_out_count;
        o_res.data.in_receive       = r_out_rx;
        case (r_out_sel)
            arq_pkg::SEL_MEM:  o_res.data.trace_entry = mem_rdata;
            arq_pkg::SEL_TAIL: o_res.data.trace_entry = r_tail;
            default:           o_res.data.trace_entry = '0;
        endcase
    end

    assign o_res.valid = r_out_valid;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_index <= r_total) && (r_total <= TW'(MAX_TRACE)))
        else $error("scan index beyond scan total");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} < (CW+1)'(MAX_TRACE))
        else $error("committed count out of range");

    a_entry_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != arq_pkg::ST_READ))
            |-> (r_out_sel == arq_pkg::SEL_ZERO))
        else $error("trace entry selected on a non-read result");

    a_no_store_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_in_valid && (r_in.operation == arq_pkg::OP_PATH) && (r_index < r_total)))
        else $error("trace store written with no scan pending");

    a_commit_uncleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_bank != r_bank)) |=> (!r_cleared && (r_count != '0)))
        else $error("bank swap without a committed trace");

endmodule

`default_nettype wire
